/* rtl/qrrs_pkg.sv */
// Shared constants, types and class codes for the quadratic real root solver.
// No dependencies; imported by every module of the block.
package qrrs_pkg;

   localparam int COEF_WIDTH  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int ROOT_WIDTH  = 34;
   localparam int CLASS_WIDTH = 3;

   // Discriminant b*b - 4*a*c, exact.
   localparam int DISC_W = 2 * COEF_WIDTH + 2;

   // Square root pipeline: one root bit per iteration.
   localparam int SQ_ITERS   = COEF_WIDTH + 2 + FRAC_BITS;
   localparam int SQ_RAD_W   = 2 * SQ_ITERS;
   localparam int SQ_ROOT_W  = SQ_ITERS;
   localparam int SQ_STEPS   = 2;
   localparam int SQ_STAGES  = (SQ_ITERS + SQ_STEPS - 1) / SQ_STEPS;

   // Quotient numerators and denominators.
   localparam int NUM_W      = COEF_WIDTH + FRAC_BITS + 3;
   localparam int DEN_W      = COEF_WIDTH + 2;
   localparam int DV_N_W     = COEF_WIDTH + FRAC_BITS + 4;
   localparam int DV_D_W     = COEF_WIDTH + 2;
   localparam int DV_STEPS   = 2;
   localparam int DV_STAGES  = (DV_N_W + DV_STEPS - 1) / DV_STEPS;

   typedef enum logic [CLASS_WIDTH-1:0] {
      CLS_INVALID = 3'd0,
      CLS_INDET   = 3'd1,
      CLS_LINEAR  = 3'd2,
      CLS_NONE    = 3'd3,
      CLS_DOUBLE  = 3'd4,
      CLS_TWO     = 3'd5
   } cls_type;

   typedef struct packed {
      logic                           vld;
      cls_type                        cls;
      logic signed [COEF_WIDTH-1:0]   a;
      logic signed [COEF_WIDTH-1:0]   b;
      logic signed [COEF_WIDTH-1:0]   c;
   } sq_meta_type;

   typedef struct packed {
      logic    vld;
      cls_type cls;
      logic    neg1;
      logic    neg2;
   } dv_meta_type;

endpackage

/* rtl/qrrs_sqrt.sv */
// Pipelined restoring square root, SQ_STEPS root bits per stage.
// Depends on qrrs_pkg.
module qrrs_sqrt import qrrs_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [SQ_RAD_W-1:0]  radicand,
   output logic [SQ_ROOT_W-1:0] root_out
);

   localparam int REM_W = SQ_ROOT_W + 2;

   logic [SQ_RAD_W-1:0]  rad_ff  [SQ_STAGES];
   logic [REM_W-1:0]     rem_ff  [SQ_STAGES];
   logic [SQ_ROOT_W-1:0] root_ff [SQ_STAGES];
   logic [SQ_RAD_W-1:0]  rad_in  [SQ_STAGES];
   logic [REM_W-1:0]     rem_in  [SQ_STAGES];
   logic [SQ_ROOT_W-1:0] root_in [SQ_STAGES];

   always_comb begin
      logic [REM_W-1:0]     rem_v;
      logic [REM_W-1:0]     rem_t;
      logic [REM_W-1:0]     trial;
      logic [SQ_ROOT_W-1:0] root_v;
      int                   idx;
      rem_v  = '0;
      rem_t  = '0;
      trial  = '0;
      root_v = '0;
      idx    = 0;
      for (int s = 0; s < SQ_STAGES; s++) begin
         if (s == 0) begin
            rad_in[s] = radicand;
            rem_v     = '0;
            root_v    = '0;
         end else begin
            rad_in[s] = rad_ff[s-1];
            rem_v     = rem_ff[s-1];
            root_v    = root_ff[s-1];
         end
         for (int j = 0; j < SQ_STEPS; j++) begin
            idx = SQ_ITERS - 1 - SQ_STEPS * s - j;
            if (idx >= 0) begin
               rem_t = {rem_v[REM_W-3:0], rad_in[s][2*idx +: 2]};
               trial = {root_v, 2'b01};
               if (rem_t >= trial) begin
                  rem_v  = rem_t - trial;
                  root_v = {root_v[SQ_ROOT_W-2:0], 1'b1};
               end else begin
                  rem_v  = rem_t;
                  root_v = {root_v[SQ_ROOT_W-2:0], 1'b0};
               end
            end
         end
         rem_in[s]  = rem_v;
         root_in[s] = root_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SQ_STAGES; s++) begin
            rad_ff[s]  <= rad_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign root_out = root_ff[SQ_STAGES-1];

endmodule

/* rtl/qrrs_div.sv */
// Pipelined restoring unsigned divider, DV_STEPS quotient bits per stage.
// Depends on qrrs_pkg.
module qrrs_div import qrrs_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [DV_N_W-1:0] dividend,
   input  logic [DV_D_W-1:0] divisor,
   output logic [DV_N_W-1:0] quotient
);

   logic [DV_N_W-1:0] num_ff [DV_STAGES];
   logic [DV_D_W-1:0] den_ff [DV_STAGES];
   logic [DV_D_W-1:0] rem_ff [DV_STAGES];
   logic [DV_N_W-1:0] quo_ff [DV_STAGES];
   logic [DV_N_W-1:0] num_in [DV_STAGES];
   logic [DV_D_W-1:0] den_in [DV_STAGES];
   logic [DV_D_W-1:0] rem_in [DV_STAGES];
   logic [DV_N_W-1:0] quo_in [DV_STAGES];

   always_comb begin
      logic [DV_D_W-1:0] rem_v;
      logic [DV_D_W:0]   rem_t;
      logic [DV_N_W-1:0] quo_v;
      int                idx;
      rem_v = '0;
      rem_t = '0;
      quo_v = '0;
      idx   = 0;
      for (int s = 0; s < DV_STAGES; s++) begin
         if (s == 0) begin
            num_in[s] = dividend;
            den_in[s] = divisor;
            rem_v     = '0;
            quo_v     = '0;
         end else begin
            num_in[s] = num_ff[s-1];
            den_in[s] = den_ff[s-1];
            rem_v     = rem_ff[s-1];
            quo_v     = quo_ff[s-1];
         end
         for (int j = 0; j < DV_STEPS; j++) begin
            idx = DV_N_W - 1 - DV_STEPS * s - j;
            if (idx >= 0) begin
               rem_t = {rem_v, num_in[s][idx]};
               if (rem_t >= {1'b0, den_in[s]}) begin
                  rem_t      = rem_t - {1'b0, den_in[s]};
                  quo_v[idx] = 1'b1;
               end
               rem_v = rem_t[DV_D_W-1:0];
            end
         end
         rem_in[s] = rem_v;
         quo_in[s] = quo_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DV_STAGES; s++) begin
            num_ff[s] <= num_in[s];
            den_ff[s] <= den_in[s];
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quotient = quo_ff[DV_STAGES-1];

endmodule

/* rtl/quadratic_real_root_solver_unit.sv */
// Quadratic real root solver: top level.
// Depends on qrrs_pkg, qrrs_sqrt and qrrs_div.
//
// Usage:
//  - Request channel (req_*): one beat carries coefficients a, b, c of
//    a*x^2 + b*x + c = 0 as signed integers. A beat is taken when req_valid
//    is high and req_stall is low.
//  - Response channel (rsp_*): one beat per request, in order, with the class
//    code and two roots in signed fixed point (FRAC_BITS fraction bits),
//    rounded to nearest with ties away from zero. Unused roots read zero.
//  - Pipeline: 40 register stages: input register, multiply, discriminant,
//    17 square root stages, divider setup, 18 divider stages, output register.
//  - Throughput: one beat per cycle while the output is not stalled. The
//    pipeline advances whenever the output register is empty or being taken.
//  - Stall: while rsp_stall holds a full output register, every stage holds
//    and req_stall is raised; nothing is dropped or repeated.
//  - Reset (synchronous, active high) clears all valid bits; data registers
//    are not cleared.
module quadratic_real_root_solver_unit import qrrs_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COEF_WIDTH-1:0] req_coef_a,
   input  logic signed [COEF_WIDTH-1:0] req_coef_b,
   input  logic signed [COEF_WIDTH-1:0] req_coef_c,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CLASS_WIDTH-1:0]       rsp_root_class,
   output logic signed [ROOT_WIDTH-1:0] rsp_root_one,
   output logic signed [ROOT_WIDTH-1:0] rsp_root_two
);

   localparam logic [DV_N_W-1:0] SAT_LIM = DV_N_W'(1) << (ROOT_WIDTH - 1);

   // Pipeline enable: advance unless a finished beat is stuck at the output.
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // Input register.
   logic                         in_vld_ff;
   logic signed [COEF_WIDTH-1:0] in_a_ff, in_b_ff, in_c_ff;

   // Multiply stage.
   logic                           mul_vld_ff;
   logic signed [2*COEF_WIDTH-1:0] mul_bb_ff, mul_ac_ff;
   logic signed [COEF_WIDTH-1:0]   mul_a_ff, mul_b_ff, mul_c_ff;

   // Discriminant stage.
   logic signed [DISC_W-1:0] disc;
   sq_meta_type              dsc_meta_in, dsc_meta_ff;
   logic [SQ_RAD_W-1:0]      dsc_rad_in, dsc_rad_ff;

   // Metadata riding alongside the square root.
   sq_meta_type          sq_meta_ff [SQ_STAGES];
   logic [SQ_ROOT_W-1:0] sq_root;
   sq_meta_type          sq_last;

   // Divider setup stage.
   dv_meta_type       set_meta_in, set_meta_ff;
   logic [DV_N_W-1:0] set_n1_in, set_n2_in, set_n1_ff, set_n2_ff;
   logic [DV_D_W-1:0] set_d_in, set_d_ff;

   // Metadata riding alongside the dividers.
   dv_meta_type       dv_meta_ff [DV_STAGES];
   logic [DV_N_W-1:0] q1, q2;
   dv_meta_type       dv_last;

   // Output register.
   logic                         rsp_valid_ff;
   logic [CLASS_WIDTH-1:0]       rsp_class_ff, rsp_class_in;
   logic signed [ROOT_WIDTH-1:0] rsp_one_ff, rsp_one_in, rsp_two_ff, rsp_two_in;

   // Round-to-nearest quotient to a saturated signed root.
   function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [DV_N_W-1:0] q,
                                                      input logic neg);
      logic [DV_N_W-1:0] qs;
      qs = q;
      if (neg && q != '0) begin
         if (q > SAT_LIM) qs = SAT_LIM;
         qs = -qs;
      end else begin
         if (q > SAT_LIM - 1'b1) qs = SAT_LIM - 1'b1;
      end
      return qs[ROOT_WIDTH-1:0];
   endfunction

   // Input register and multiply stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff  <= req_valid;
         mul_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_a_ff   <= req_coef_a;
         in_b_ff   <= req_coef_b;
         in_c_ff   <= req_coef_c;
         mul_bb_ff <= in_b_ff * in_b_ff;
         mul_ac_ff <= in_a_ff * in_c_ff;
         mul_a_ff  <= in_a_ff;
         mul_b_ff  <= in_b_ff;
         mul_c_ff  <= in_c_ff;
      end
   end

   // Discriminant and classification; feed the square root only for two roots.
   always_comb begin
      disc = DISC_W'(mul_bb_ff) - (DISC_W'(mul_ac_ff) <<< 2);
      dsc_meta_in.vld = mul_vld_ff;
      dsc_meta_in.a   = mul_a_ff;
      dsc_meta_in.b   = mul_b_ff;
      dsc_meta_in.c   = mul_c_ff;
      if (mul_a_ff == '0) begin
         if (mul_b_ff == '0) begin
            dsc_meta_in.cls = (mul_c_ff == '0) ? CLS_INDET : CLS_INVALID;
         end else begin
            dsc_meta_in.cls = CLS_LINEAR;
         end
      end else if (disc[DISC_W-1]) begin
         dsc_meta_in.cls = CLS_NONE;
      end else if (disc == '0) begin
         dsc_meta_in.cls = CLS_DOUBLE;
      end else begin
         dsc_meta_in.cls = CLS_TWO;
      end
      if (dsc_meta_in.cls == CLS_TWO) begin
         dsc_rad_in = SQ_RAD_W'(disc[DISC_W-2:0]) << (2 * FRAC_BITS);
      end else begin
         dsc_rad_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dsc_meta_ff.vld <= 1'b0;
      end else if (adv) begin
         dsc_meta_ff <= dsc_meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dsc_rad_ff <= dsc_rad_in;
      end
   end

   qrrs_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (dsc_rad_ff),
      .root_out (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQ_STAGES; i++) sq_meta_ff[i].vld <= 1'b0;
      end else if (adv) begin
         sq_meta_ff[0] <= dsc_meta_ff;
         for (int i = 1; i < SQ_STAGES; i++) sq_meta_ff[i] <= sq_meta_ff[i-1];
      end
   end

   assign sq_last = sq_meta_ff[SQ_STAGES-1];

   // Divider setup: pick numerator and denominator per class, then form
   // (2|num| + |den|) / (2|den|) so a floor division rounds to nearest.
   always_comb begin
      logic signed [NUM_W-1:0] neg_b, neg_c, sq_s, n1, n2;
      logic signed [DEN_W-1:0] den;
      logic [NUM_W-1:0]        m1, m2;
      logic [DEN_W-1:0]        dm;
      neg_b = -(NUM_W'(sq_last.b) <<< FRAC_BITS);
      neg_c = -(NUM_W'(sq_last.c) <<< FRAC_BITS);
      sq_s  = signed'(NUM_W'(sq_root));
      case (sq_last.cls)
         CLS_LINEAR: begin
            n1  = neg_c;
            n2  = neg_c;
            den = DEN_W'(sq_last.b);
         end
         CLS_DOUBLE: begin
            n1  = neg_b;
            n2  = neg_b;
            den = DEN_W'(sq_last.a) <<< 1;
         end
         CLS_TWO: begin
            n1  = neg_b + sq_s;
            n2  = neg_b - sq_s;
            den = DEN_W'(sq_last.a) <<< 1;
         end
         default: begin
            n1  = '0;
            n2  = '0;
            den = DEN_W'(1);
         end
      endcase
      m1 = n1[NUM_W-1] ? -n1 : n1;
      m2 = n2[NUM_W-1] ? -n2 : n2;
      dm = den[DEN_W-1] ? -den : den;
      set_n1_in        = (DV_N_W'(m1) << 1) + DV_N_W'(dm);
      set_n2_in        = (DV_N_W'(m2) << 1) + DV_N_W'(dm);
      set_d_in         = DV_D_W'(dm) << 1;
      set_meta_in.vld  = sq_last.vld;
      set_meta_in.cls  = sq_last.cls;
      set_meta_in.neg1 = n1[NUM_W-1] ^ den[DEN_W-1];
      set_meta_in.neg2 = n2[NUM_W-1] ^ den[DEN_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_meta_ff.vld <= 1'b0;
      end else if (adv) begin
         set_meta_ff <= set_meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         set_n1_ff <= set_n1_in;
         set_n2_ff <= set_n2_in;
         set_d_ff  <= set_d_in;
      end
   end

   qrrs_div u_div_one (
      .clock    (clock),
      .en       (adv),
      .dividend (set_n1_ff),
      .divisor  (set_d_ff),
      .quotient (q1)
   );

   qrrs_div u_div_two (
      .clock    (clock),
      .en       (adv),
      .dividend (set_n2_ff),
      .divisor  (set_d_ff),
      .quotient (q2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DV_STAGES; i++) dv_meta_ff[i].vld <= 1'b0;
      end else if (adv) begin
         dv_meta_ff[0] <= set_meta_ff;
         for (int i = 1; i < DV_STAGES; i++) dv_meta_ff[i] <= dv_meta_ff[i-1];
      end
   end

   assign dv_last = dv_meta_ff[DV_STAGES-1];

   // Final sign, saturation and zeroing of unused roots.
   always_comb begin
      rsp_class_in = dv_last.cls;
      if (dv_last.cls == CLS_LINEAR || dv_last.cls == CLS_DOUBLE
          || dv_last.cls == CLS_TWO) begin
         rsp_one_in = signed'(sat_root(q1, dv_last.neg1));
         rsp_two_in = signed'(sat_root(q2, dv_last.neg2));
      end else begin
         rsp_one_in = '0;
         rsp_two_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_class_ff <= rsp_class_in;
         rsp_one_ff   <= rsp_one_in;
         rsp_two_ff   <= rsp_two_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root_class = rsp_class_ff;
   assign rsp_root_one   = rsp_one_ff;
   assign rsp_root_two   = rsp_two_ff;

endmodule

/* dv/quadratic_real_root_solver_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for quadratic_real_root_solver_unit: random and corner coefficient
// triples are checked against a bit-exact root predictor. Depends on qrrs_pkg and the RTL.
module quadratic_real_root_solver_unit_tb;
   import qrrs_pkg::*;

   typedef struct {
      cls_type                 cls;
      logic [ROOT_WIDTH-1:0]   one;
      logic [ROOT_WIDTH-1:0]   two;
   } roots_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [COEF_WIDTH-1:0] req_coef_a;
   logic signed [COEF_WIDTH-1:0] req_coef_b;
   logic signed [COEF_WIDTH-1:0] req_coef_c;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [CLASS_WIDTH-1:0]       rsp_root_class;
   logic signed [ROOT_WIDTH-1:0] rsp_root_one;
   logic signed [ROOT_WIDTH-1:0] rsp_root_two;

   roots_type pending_roots[$];
   int        fail_count = 0;
   bit        idle_enable = 1'b1;

   quadratic_real_root_solver_unit uut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   // Divide, round half away from zero, saturate to the root width.
   function automatic logic [ROOT_WIDTH-1:0] round_div(longint num, longint den);
      longint unsigned m, d, q, lim;
      bit neg;
      m   = (num < 0) ? -num : num;
      d   = (den < 0) ? -den : den;
      q   = (2 * m + d) / (2 * d);
      neg = ((num < 0) != (den < 0)) && (q != 0);
      lim = 64'd1 << (ROOT_WIDTH - 1);
      if (neg) begin
         if (q > lim) q = lim;
         return ROOT_WIDTH'(-q);
      end
      if (q > lim - 1) q = lim - 1;
      return ROOT_WIDTH'(q);
   endfunction

   // Restoring square root of disc * 2^(2*FRAC_BITS), truncated.
   function automatic longint unsigned fixed_sqrt(longint unsigned disc);
      longint unsigned root, rem, pair, trial;
      root = 0;
      rem  = 0;
      for (int i = COEF_WIDTH + 2 + FRAC_BITS - 1; i >= 0; i--) begin
         pair = (i >= FRAC_BITS) ? (disc >> (2 * (i - FRAC_BITS))) & 3 : 0;
         rem   = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic roots_type solve_roots(longint a, longint b, longint c);
      roots_type r;
      longint disc, s, scale;
      scale = 64'sd1 << FRAC_BITS;
      r.one = '0;
      r.two = '0;
      if (a == 0) begin
         if (b == 0) begin
            r.cls = (c == 0) ? CLS_INDET : CLS_INVALID;
         end else begin
            r.cls = CLS_LINEAR;
            r.one = round_div(-c * scale, b);
            r.two = r.one;
         end
      end else begin
         disc = b * b - 4 * a * c;
         if (disc < 0) begin
            r.cls = CLS_NONE;
         end else if (disc == 0) begin
            r.cls = CLS_DOUBLE;
            r.one = round_div(-b * scale, 2 * a);
            r.two = r.one;
         end else begin
            s = longint'(fixed_sqrt(disc));
            r.cls = CLS_TWO;
            r.one = round_div(-b * scale + s, 2 * a);
            r.two = round_div(-b * scale - s, 2 * a);
         end
      end
      return r;
   endfunction

   // Send one beat; hold the payload until taken, then maybe idle.
   task automatic send_coefs(int a, int b, int c);
      int gap;
      req_valid  <= 1'b1;
      req_coef_a <= a[COEF_WIDTH-1:0];
      req_coef_b <= b[COEF_WIDTH-1:0];
      req_coef_c <= c[COEF_WIDTH-1:0];
      do @(posedge clock); while (req_stall);
      pending_roots.push_back(solve_roots(longint'(signed'(a[COEF_WIDTH-1:0])),
                                          longint'(signed'(b[COEF_WIDTH-1:0])),
                                          longint'(signed'(c[COEF_WIDTH-1:0]))));
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every expected response has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_roots.size() != 0) @(negedge clock);
   endtask

   function automatic int rand_coef();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(0, 8) - 4;
         2: return $urandom_range(0, 200) - 100;
         3: return $urandom_range(0, 1) ? 32767 : -32768;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   task automatic test_corners();
      int vals[5] = '{0, 1, -1, 32767, -32768};
      foreach (vals[i]) send_coefs(0, 0, vals[i]);
      send_coefs(0, 3, -7);
      send_coefs(0, -32768, 32767);
      send_coefs(0, 1, -32768);
      send_coefs(1, -2, 1);
      send_coefs(-32768, -32768, 32767);
      send_coefs(32767, -32768, -32768);
      send_coefs(-32768, -32768, -32768);
      send_coefs(1, 0, 1);
      send_coefs(32767, 0, 32767);
      send_coefs(2, 3, 1);
      send_coefs(-3, 5, 7);
      send_coefs(1, 32767, -32768);
      send_coefs(1, 1, 0);
      send_coefs(3, 2, 1);
   endtask

   // Hold the sender off until the pipe is empty.
   task automatic test_drain_pause();
      drain_results();
      repeat (50) @(negedge clock);
      send_coefs(4, 4, 1);
      send_coefs(1, 5, 6);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_coefs($urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 65535) - 32768);
         else
            send_coefs(rand_coef(), rand_coef(), rand_coef());
      end
   endtask

   // Factored quadratics: a*(x-p)*(x-q) keeps double roots and exact roots common.
   task automatic test_factored(int count);
      int a, p, q;
      for (int i = 0; i < count; i++) begin
         a = $urandom_range(1, 20) * ($urandom_range(0, 1) ? 1 : -1);
         p = $urandom_range(0, 60) - 30;
         q = $urandom_range(0, 1) ? p : $urandom_range(0, 60) - 30;
         send_coefs(a, -a * (p + q), a * p * q);
      end
   endtask

   // Randomly stall the response side in bursts; stop stalling near the end.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check each response beat against the oldest prediction.
   always @(posedge clock) begin
      roots_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_roots.size() == 0) begin
            $error("response beat with nothing expected");
            fail_count++;
         end else begin
            e = pending_roots.pop_front();
            if (rsp_root_class !== e.cls) begin
               $error("root_class expected %0d actual %0d", e.cls, rsp_root_class);
               fail_count++;
            end
            if (rsp_root_one !== e.one) begin
               $error("root_one expected %0d actual %0d", $signed(e.one), rsp_root_one);
               fail_count++;
            end
            if (rsp_root_two !== e.two) begin
               $error("root_two expected %0d actual %0d", $signed(e.two), rsp_root_two);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_corners();
      test_drain_pause();
      test_random(600);
      test_factored(300);
      idle_enable = 1'b0;
      test_random(200);
      drain_results();
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending_roots.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

/* quadratic_real_root_solver_unit.f */
rtl/qrrs_pkg.sv
rtl/qrrs_sqrt.sv
rtl/qrrs_div.sv
rtl/quadratic_real_root_solver_unit.sv
dv/quadratic_real_root_solver_unit_tb.sv
